@@ rtl/shs_pkg.sv @@
// Package: SHA-256 constants, round functions and sequencer state type.
`timescale 1ns / 1ps

package shs_pkg;

    // Initial hash value H0..H7
    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Round constants
    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Command codes
    localparam logic CMD_ABSORB   = 1'b0;
    localparam logic CMD_FINALIZE = 1'b1;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ROUND = 5'b00010,
        S_FOLD  = 5'b00100,
        S_LEN   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

@@ rtl/shs_if.sv @@
// Interfaces: byte/command input channel and digest word output channel.
`timescale 1ns / 1ps

interface shs_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface shs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;

    modport source (output valid, output digest_word, output word_index, output last,
                    input ready);
    modport sink   (input valid, input digest_word, input word_index, input last,
                    output ready);
endinterface

@@ rtl/sha256_stream_hasher_core.sv @@
// Top level: SHA-256 stream hasher with one shared round unit.
//
//  channel | dir | payload                              | transfer
//  i_in    | in  | command[0], data_byte[7:0]           | valid && ready
//  o_out   | out | digest_word[31:0], word_index, last  | valid && ready
//
// Absorb: the 64th byte of a block starts 64 rounds through the single round
//   unit, then one fold into the hash. Finalize: pad byte, a compression
//   if it spills into a second block, the length word, a final compression,
//   then 8 digest transfers, one per cycle when o_out.ready is high.
// Input is not ready while a block compresses or the digest is being sent.
// Synchronous active-low reset loads the initial hash and clears the buffer.
`timescale 1ns / 1ps

module sha256_stream_hasher_core
    import shs_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    shs_in_if.sink          i_in,
    shs_out_if.source       o_out
);

    t_state      r_state, n_state;
    logic [31:0] r_hash [8];
    logic [31:0] r_v    [8];
    logic [31:0] r_buf  [16];
    logic [31:0] r_count;
    logic [31:0] r_len;
    logic [5:0]  r_round;
    logic [2:0]  r_idx;
    logic        r_fin;
    logic        r_last;

    logic        in_xfer;
    logic        out_xfer;
    logic [5:0]  off;
    logic [7:0]  wr_byte;
    logic        start_rounds;

    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_xfer = o_out.valid && o_out.ready;
    assign off      = r_count[5:0];
    assign wr_byte  = (i_in.command == CMD_FINALIZE) ? PAD_BYTE : i_in.data_byte;

    // Handshake and result fields
    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = (r_state == S_OUT);
    assign o_out.digest_word = r_hash[r_idx];
    assign o_out.word_index  = r_idx;
    assign o_out.last        = (r_idx == 3'd7);

    // Shared round unit: schedule word and compression step
    always_comb begin
        w_new = r_buf[0] + small_sigma0(r_buf[1]) + r_buf[9] + small_sigma1(r_buf[14]);
        ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1    = r_v[7] + big_sigma1(r_v[4]) + ch + ROUND_K[r_round] + r_buf[0];
        t2    = big_sigma0(r_v[0]) + maj;
    end

    // Sequencer
    always_comb begin
        n_state      = r_state;
        start_rounds = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_in.command == CMD_FINALIZE) begin
                        // pad fits with the length only below byte 56
                        if (off >= 6'd56) begin
                            n_state      = S_ROUND;
                            start_rounds = 1'b1;
                        end else begin
                            n_state = S_LEN;
                        end
                    end else if (off == 6'd63) begin
                        n_state      = S_ROUND;
                        start_rounds = 1'b1;
                    end
                end
            end
            S_ROUND: begin
                if (r_round == 6'd63) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                if (!r_fin) begin
                    n_state = S_IDLE;
                end else if (!r_last) begin
                    n_state = S_LEN;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_LEN: begin
                n_state      = S_ROUND;
                start_rounds = 1'b1;
            end
            S_OUT: begin
                if (out_xfer && (r_idx == 3'd7)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_round <= '0;
            r_idx   <= '0;
            r_fin   <= 1'b0;
            r_last  <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= IV[i];
            end
            for (int i = 0; i < 16; i++) begin
                r_buf[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            // Load working variables at the start of each compression
            if (start_rounds) begin
                r_round <= '0;
                for (int i = 0; i < 8; i++) begin
                    r_v[i] <= r_hash[i];
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_buf[off[5:2]][{~off[1:0], 3'b000} +: 8] <= wr_byte;
                        r_count <= r_count + 32'd1;
                        if (i_in.command == CMD_FINALIZE) begin
                            r_fin <= 1'b1;
                            r_len <= {r_count[28:0], 3'b000};
                        end
                    end
                end
                S_ROUND: begin
                    r_round <= r_round + 6'd1;
                    // message schedule slides one word per round
                    for (int i = 0; i < 15; i++) begin
                        r_buf[i] <= r_buf[i + 1];
                    end
                    r_buf[15] <= w_new;
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                end
                S_FOLD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_hash[i] <= r_hash[i] + r_v[i];
                    end
                    for (int i = 0; i < 16; i++) begin
                        r_buf[i] <= '0;
                    end
                end
                S_LEN: begin
                    r_buf[15] <= r_len;
                    r_last    <= 1'b1;
                end
                S_OUT: begin
                    if (out_xfer) begin
                        r_idx <= r_idx + 3'd1;
                        // back to the initial state after the last word
                        if (r_idx == 3'd7) begin
                            r_count <= '0;
                            r_fin   <= 1'b0;
                            r_last  <= 1'b0;
                            for (int i = 0; i < 8; i++) begin
                                r_hash[i] <= IV[i];
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/shs_checker.sv @@
// Checker: port-level properties of the stream hasher, bound to the top level.
`timescale 1ns / 1ps

module shs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_command,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_out_word_index,
    input logic        i_out_last
);

    // Input is never taken while the digest is being sent
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready while digest pending");

    // An absorbed byte never produces a result on the next cycle
    a_absorb_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && !i_in_command) |=> !i_out_valid)
        else $error("result after absorb");

    // Digest words come out in order
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_out_last) |=>
            (i_out_valid && (i_out_word_index == $past(i_out_word_index) + 3'd1)))
        else $error("digest word order broken");

    // Last word ends the burst
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_last) |=> !i_out_valid)
        else $error("result after last word");

    // Last flag marks word seven
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_last == (i_out_word_index == 3'd7)))
        else $error("last flag on wrong word");

endmodule

bind sha256_stream_hasher_core shs_checker u_shs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_in_command     (i_in.command),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_word_index (o_out.word_index),
    .i_out_last       (o_out.last)
);
